@@ rtl/masked_zscore_normalizer_defines.svh @@
// assertion macros for the normalizer
`ifndef MASKED_ZSCORE_NORMALIZER_DEFINES_SVH
`define MASKED_ZSCORE_NORMALIZER_DEFINES_SVH

// property holds in the same cycle
`define MZN_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mzn check failed");

// property holds in the next cycle
`define MZN_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mzn check failed");

`endif

@@ rtl/mzn_pkg.sv @@
package mzn_pkg;

   localparam int STORE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int SAMPLE_W    = 24;
   localparam int DIFF_W      = SAMPLE_W + 1;
   localparam int SUM_W       = SAMPLE_W + ADDR_W;
   localparam int SQ_W        = 2 * DIFF_W;
   localparam int ACC_W       = 62;
   localparam int DIV_W       = 62;
   localparam int DIVISOR_W   = 24;
   localparam int STEP_W      = 6;
   localparam int ROOT_W      = DIV_W / 2;
   localparam int SQRT_CNT_W  = 5;
   localparam int FRAC_W      = 16;

   localparam logic [STEP_W-1:0] MEAN_STEPS = STEP_W'(SUM_W + 1);
   localparam logic [STEP_W-1:0] READ_STEPS = STEP_W'(DIFF_W + FRAC_W);
   localparam logic [STEP_W-1:0] VAR_STEPS  = STEP_W'(DIV_W);
   localparam logic [SQRT_CNT_W-1:0] SQRT_STEPS = SQRT_CNT_W'(ROOT_W);

   localparam logic [CNT_W-1:0]    DEPTH_COUNT = CNT_W'(STORE_DEPTH);
   localparam logic [SAMPLE_W-1:0] Q_MAX = 24'h7FFFFF;
   localparam logic [SAMPLE_W-1:0] Q_MIN = 24'h800000;

   localparam logic [1:0] OP_CLEAR   = 2'd0;
   localparam logic [1:0] OP_LOAD    = 2'd1;
   localparam logic [1:0] OP_COMPUTE = 2'd2;
   localparam logic [1:0] OP_READ    = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_BAD   = 2'd3;

   typedef struct packed {
      logic accept;
      logic mean_set;
      logic var_start;
      logic sqrt_start;
      logic dev_set;
      logic read_eval;
      logic read_set;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic tally_zero;
      logic div_busy;
      logic scan_busy;
      logic sqrt_busy;
      logic read_div;
      logic out_free;
   } sts_type;

endpackage

@@ rtl/mzn_div.sv @@
module mzn_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [mzn_pkg::DIV_W-1:0]        dividend,
   input  logic [mzn_pkg::DIVISOR_W-1:0]    divisor,
   input  logic [mzn_pkg::STEP_W-1:0]       steps,
   output logic                             busy,
   output logic [mzn_pkg::DIV_W-1:0]        quotient
);

   logic [mzn_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [mzn_pkg::DIVISOR_W-1:0] rem_ff, rem_in, dsr_ff, dsr_in;
   logic [mzn_pkg::STEP_W-1:0]    cnt_ff, cnt_in;
   logic [mzn_pkg::DIVISOR_W:0]   trial, diff;
   logic                          ge;

   // dividend comes in left aligned, quotient ends in the low bits
   assign trial = {rem_ff, quo_ff[mzn_pkg::DIV_W-1]};
   assign ge    = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = steps;
      end else if (cnt_ff != '0) begin
         quo_in = {quo_ff[mzn_pkg::DIV_W-2:0], ge};
         rem_in = ge ? diff[mzn_pkg::DIVISOR_W-1:0] : trial[mzn_pkg::DIVISOR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = quo_ff;

endmodule

@@ rtl/mzn_ctrl.sv @@
module mzn_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic [1:0]           req_op,
   input  mzn_pkg::sts_type     sts,
   output logic                 req_tready,
   output mzn_pkg::cmd_type     cmd
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_MEAN_DIV  = 3'd1;
   localparam logic [2:0] S_SCAN      = 3'd2;
   localparam logic [2:0] S_VAR_DIV   = 3'd3;
   localparam logic [2:0] S_SQRT      = 3'd4;
   localparam logic [2:0] S_READ_EVAL = 3'd5;
   localparam logic [2:0] S_READ_DIV  = 3'd6;
   localparam logic [2:0] S_FINISH    = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE) && sts.out_free;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.accept = 1'b1;
               unique case (req_op)
                  mzn_pkg::OP_COMPUTE: state_in = sts.tally_zero ? S_FINISH : S_MEAN_DIV;
                  mzn_pkg::OP_READ:    state_in = S_READ_EVAL;
                  default:             state_in = S_FINISH;
               endcase
            end
         end
         S_MEAN_DIV: begin
            if (!sts.div_busy) begin
               cmd.mean_set = 1'b1;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!sts.scan_busy) begin
               cmd.var_start = 1'b1;
               state_in      = S_VAR_DIV;
            end
         end
         S_VAR_DIV: begin
            if (!sts.div_busy) begin
               cmd.sqrt_start = 1'b1;
               state_in       = S_SQRT;
            end
         end
         S_SQRT: begin
            if (!sts.sqrt_busy) begin
               cmd.dev_set = 1'b1;
               state_in    = S_FINISH;
            end
         end
         S_READ_EVAL: begin
            cmd.read_eval = 1'b1;
            state_in      = sts.read_div ? S_READ_DIV : S_FINISH;
         end
         S_READ_DIV: begin
            if (!sts.div_busy) begin
               cmd.read_set = 1'b1;
               state_in     = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/mzn_dpath.sv @@
module mzn_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  mzn_pkg::cmd_type                  cmd,
   output mzn_pkg::sts_type                  sts,
   input  logic [1:0]                        req_op,
   input  logic [mzn_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic [mzn_pkg::ADDR_W-1:0]        req_index,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [mzn_pkg::SAMPLE_W-1:0]      rsp_value,
   output logic [mzn_pkg::SAMPLE_W-1:0]      rsp_mean,
   output logic [mzn_pkg::SAMPLE_W-1:0]      rsp_deviation,
   output logic [mzn_pkg::CNT_W-1:0]         rsp_count,
   output logic [1:0]                        rsp_status
);

   localparam int SW = mzn_pkg::SAMPLE_W;

   logic [SW-1:0] store [mzn_pkg::STORE_DEPTH];
   logic [SW-1:0] rd_data_ff;
   logic [mzn_pkg::ADDR_W-1:0] rd_addr;

   logic [mzn_pkg::CNT_W-1:0] loaded_ff, loaded_in, tally_ff, tally_in;
   logic [mzn_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [SW-1:0] mean_ff, mean_in, dev_ff, dev_in, value_ff, value_in;
   logic          stats_ff, stats_in, bad_ff, bad_in, neg_ff, neg_in;
   logic [1:0]    status_ff, status_in;

   logic [mzn_pkg::CNT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic                       issue_ff, issue_in, v1_ff, v2_ff, v3_ff;
   logic [mzn_pkg::DIFF_W-1:0] ad_ff;
   logic [mzn_pkg::SQ_W-1:0]   sq_ff;
   logic [mzn_pkg::ACC_W-1:0]  acc_ff, acc_in;

   logic [mzn_pkg::DIV_W-1:0]      src_ff, src_in;
   logic [mzn_pkg::ROOT_W+1-1:0]   rem_ff, rem_in;
   logic [mzn_pkg::ROOT_W-1:0]     root_ff, root_in;
   logic [mzn_pkg::SQRT_CNT_W-1:0] sq_cnt_ff, sq_cnt_in;
   logic [mzn_pkg::ROOT_W+2:0]     r4, trial;

   logic                  out_valid_ff, out_valid_in;
   logic [SW-1:0]         out_value_ff, out_mean_ff, out_dev_ff;
   logic [mzn_pkg::CNT_W-1:0] out_count_ff;
   logic [1:0]            out_status_ff;

   logic                          div_start, div_busy;
   logic [mzn_pkg::DIV_W-1:0]     div_dividend, quotient;
   logic [mzn_pkg::STEP_W-1:0]    div_steps;
   logic [mzn_pkg::SUM_W-1:0]     sum_mag;
   logic [mzn_pkg::SUM_W:0]       mean_num;
   logic [mzn_pkg::DIFF_W-1:0]    rd_diff, rd_mag, scan_diff;
   logic                          full, zero_case, read_div;
   logic [mzn_pkg::SUM_W:0]       mean_q;
   logic [mzn_pkg::DIFF_W+mzn_pkg::FRAC_W-1:0] read_q;

   assign full = loaded_ff == mzn_pkg::DEPTH_COUNT;

   // store: one write port for loads, one registered read port
   assign rd_addr = issue_ff ? scan_idx_ff[mzn_pkg::ADDR_W-1:0] : req_index;

   always_ff @(posedge clock) begin
      if (cmd.accept && req_op == mzn_pkg::OP_LOAD && !full) begin
         store[loaded_ff[mzn_pkg::ADDR_W-1:0]] <= req_sample;
      end
      rd_data_ff <= store[rd_addr];
   end

   // rounded mean numerator: |sum| + tally/2
   assign sum_mag  = sum_ff[mzn_pkg::SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;
   assign mean_num = {1'b0, sum_mag} + {{(mzn_pkg::SUM_W+1-mzn_pkg::CNT_W+1){1'b0}},
                     tally_ff[mzn_pkg::CNT_W-1:1]};
   assign mean_q   = quotient[mzn_pkg::SUM_W:0];

   // read evaluation on the fetched sample
   assign rd_diff   = {rd_data_ff[SW-1], rd_data_ff} - {mean_ff[SW-1], mean_ff};
   assign rd_mag    = rd_diff[mzn_pkg::DIFF_W-1] ? (~rd_diff + 1'b1) : rd_diff;
   assign zero_case = (rd_data_ff == '0) || (rd_diff == '0);
   assign read_div  = !bad_ff && !zero_case && (dev_ff != '0);
   assign read_q    = quotient[mzn_pkg::DIFF_W+mzn_pkg::FRAC_W-1:0];

   assign scan_diff = {rd_data_ff[SW-1], rd_data_ff} - {mean_ff[SW-1], mean_ff};

   always_comb begin
      div_start    = 1'b0;
      div_dividend = {mean_num, {(mzn_pkg::DIV_W-mzn_pkg::SUM_W-1){1'b0}}};
      div_steps    = mzn_pkg::MEAN_STEPS;
      priority if (cmd.accept && req_op == mzn_pkg::OP_COMPUTE && tally_ff != '0) begin
         div_start = 1'b1;
      end else if (cmd.var_start) begin
         div_start    = 1'b1;
         div_dividend = acc_ff;
         div_steps    = mzn_pkg::VAR_STEPS;
      end else if (cmd.read_eval && read_div) begin
         div_start    = 1'b1;
         div_dividend = {rd_mag, {mzn_pkg::FRAC_W{1'b0}},
                         {(mzn_pkg::DIV_W-mzn_pkg::DIFF_W-mzn_pkg::FRAC_W){1'b0}}};
         div_steps    = mzn_pkg::READ_STEPS;
      end
   end

   mzn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (cmd.read_eval ? dev_ff :
                 {{(mzn_pkg::DIVISOR_W-mzn_pkg::CNT_W){1'b0}}, tally_ff}),
      .steps    (div_steps),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // main state and command effects
   always_comb begin
      loaded_in = loaded_ff;
      tally_in  = tally_ff;
      sum_in    = sum_ff;
      mean_in   = mean_ff;
      dev_in    = dev_ff;
      stats_in  = stats_ff;
      value_in  = value_ff;
      status_in = status_ff;
      bad_in    = bad_ff;
      neg_in    = neg_ff;
      if (cmd.accept) begin
         value_in  = '0;
         status_in = mzn_pkg::ST_OK;
         unique case (req_op)
            mzn_pkg::OP_CLEAR: begin
               loaded_in = '0;
               tally_in  = '0;
               sum_in    = '0;
               mean_in   = '0;
               dev_in    = '0;
               stats_in  = 1'b0;
            end
            mzn_pkg::OP_LOAD: begin
               stats_in = 1'b0;
               if (full) begin
                  status_in = mzn_pkg::ST_FULL;
               end else begin
                  loaded_in = loaded_ff + 1'b1;
                  if (req_sample != '0) begin
                     tally_in = tally_ff + 1'b1;
                     sum_in   = sum_ff + {{(mzn_pkg::SUM_W-SW){req_sample[SW-1]}}, req_sample};
                  end
               end
            end
            mzn_pkg::OP_COMPUTE: begin
               if (tally_ff == '0) begin
                  mean_in   = '0;
                  dev_in    = '0;
                  stats_in  = 1'b0;
                  status_in = mzn_pkg::ST_EMPTY;
               end
            end
            default: begin
               bad_in = !stats_ff || ({1'b0, req_index} >= loaded_ff);
            end
         endcase
      end
      if (cmd.mean_set) begin
         mean_in = sum_ff[mzn_pkg::SUM_W-1] ? (~mean_q[SW-1:0] + 1'b1) : mean_q[SW-1:0];
      end
      if (cmd.dev_set) begin
         dev_in   = (root_ff[mzn_pkg::ROOT_W-1:SW] != '0) ? {SW{1'b1}} : root_ff[SW-1:0];
         stats_in = 1'b1;
      end
      if (cmd.read_eval) begin
         neg_in = rd_diff[mzn_pkg::DIFF_W-1];
         priority if (bad_ff) begin
            status_in = mzn_pkg::ST_BAD;
         end else if (zero_case) begin
            value_in = '0;
         end else if (dev_ff == '0) begin
            value_in = rd_diff[mzn_pkg::DIFF_W-1] ? mzn_pkg::Q_MIN : mzn_pkg::Q_MAX;
         end
      end
      if (cmd.read_set) begin
         if (neg_ff) begin
            value_in = (read_q > {{(mzn_pkg::DIFF_W+mzn_pkg::FRAC_W-SW){1'b0}}, mzn_pkg::Q_MIN})
                       ? mzn_pkg::Q_MIN : (~read_q[SW-1:0] + 1'b1);
         end else begin
            value_in = (read_q > {{(mzn_pkg::DIFF_W+mzn_pkg::FRAC_W-SW){1'b0}}, mzn_pkg::Q_MAX})
                       ? mzn_pkg::Q_MAX : read_q[SW-1:0];
         end
      end
   end

   // store walk: fetch, |s - mean|, square, accumulate
   always_comb begin
      scan_idx_in = scan_idx_ff;
      issue_in    = issue_ff;
      acc_in      = acc_ff;
      if (cmd.mean_set) begin
         scan_idx_in = '0;
         issue_in    = loaded_ff != '0;
         acc_in      = '0;
      end else begin
         if (issue_ff) begin
            scan_idx_in = scan_idx_ff + 1'b1;
            if (scan_idx_in == loaded_ff) begin
               issue_in = 1'b0;
            end
         end
         if (v3_ff) begin
            acc_in = acc_ff + {{(mzn_pkg::ACC_W-mzn_pkg::SQ_W){1'b0}}, sq_ff};
         end
      end
   end

   // square root, two radicand bits a step
   assign r4    = {rem_ff, src_ff[mzn_pkg::DIV_W-1 -: 2]};
   assign trial = {1'b0, root_ff, 2'b01};

   always_comb begin
      src_in    = src_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      sq_cnt_in = sq_cnt_ff;
      if (cmd.sqrt_start) begin
         src_in    = quotient;
         rem_in    = '0;
         root_in   = '0;
         sq_cnt_in = mzn_pkg::SQRT_STEPS;
      end else if (sq_cnt_ff != '0) begin
         src_in    = {src_ff[mzn_pkg::DIV_W-3:0], 2'b00};
         sq_cnt_in = sq_cnt_ff - 1'b1;
         if (r4 >= trial) begin
            rem_in  = (mzn_pkg::ROOT_W+1)'(r4 - trial);
            root_in = {root_ff[mzn_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = r4[mzn_pkg::ROOT_W:0];
            root_in = {root_ff[mzn_pkg::ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign out_valid_in = cmd.finish | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= '0;
         tally_ff     <= '0;
         sum_ff       <= '0;
         mean_ff      <= '0;
         dev_ff       <= '0;
         stats_ff     <= 1'b0;
         issue_ff     <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         sq_cnt_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         loaded_ff    <= loaded_in;
         tally_ff     <= tally_in;
         sum_ff       <= sum_in;
         mean_ff      <= mean_in;
         dev_ff       <= dev_in;
         stats_ff     <= stats_in;
         issue_ff     <= issue_in;
         v1_ff        <= issue_ff;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         sq_cnt_ff    <= sq_cnt_in;
         out_valid_ff <= out_valid_in;
      end
      value_ff    <= value_in;
      status_ff   <= status_in;
      bad_ff      <= bad_in;
      neg_ff      <= neg_in;
      scan_idx_ff <= scan_idx_in;
      acc_ff      <= acc_in;
      ad_ff       <= scan_diff[mzn_pkg::DIFF_W-1] ? (~scan_diff + 1'b1) : scan_diff;
      sq_ff       <= ad_ff * ad_ff;
      src_ff      <= src_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      if (cmd.finish) begin
         out_value_ff  <= value_ff;
         out_mean_ff   <= mean_ff;
         out_dev_ff    <= dev_ff;
         out_count_ff  <= tally_ff;
         out_status_ff <= status_ff;
      end
   end

   always_comb begin
      sts            = '0;
      sts.tally_zero = tally_ff == '0;
      sts.div_busy   = div_busy;
      sts.scan_busy  = issue_ff | v1_ff | v2_ff | v3_ff;
      sts.sqrt_busy  = sq_cnt_ff != '0;
      sts.read_div   = read_div;
      sts.out_free   = !out_valid_ff || rsp_tready;
   end

   assign rsp_tvalid    = out_valid_ff;
   assign rsp_value     = out_value_ff;
   assign rsp_mean      = out_mean_ff;
   assign rsp_deviation = out_dev_ff;
   assign rsp_count     = out_count_ff;
   assign rsp_status    = out_status_ff;

endmodule

@@ rtl/masked_zscore_normalizer.sv @@
// z-score normalizer over a store of up to 4096 signed Q8.16 samples.
// req channel: one command word per handshake, op in req_tuser (clear, load,
// compute, read); sample and read index in req_tdata.
// rsp channel: exactly one word per command with the normalized value, the
// current mean, deviation, nonzero count, and a status code in rsp_tuser.
// clear and load: the result passes through the finish state into the output register.
// read: when a divide is needed, the quotient comes from the 41-step serial divider.
// compute: a 37-step divide for the mean, a pipelined walk of the store (one
// entry a cycle through the single read port), a 62-step divide for the variance,
// a 31-step square root.
// one command is worked at a time; the next is taken once the previous
// result is done and the output register is free or being drained.
// a stalled rsp_tready holds the result in the output register and blocks
// further commands. synchronous reset empties the store (count zero), clears
// mean, deviation and the computed flag; no clearing pass is needed.
module masked_zscore_normalizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // sample[23:0], index[35:24], zero pad
   input  logic [1:0]  req_tuser,  // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,  // value[23:0], mean[47:24], deviation[71:48],
                                   // nonzero_count[84:72], zero pad
   output logic [1:0]  rsp_tuser   // status[1:0]
);

`include "masked_zscore_normalizer_defines.svh"

   mzn_pkg::cmd_type cmd;
   mzn_pkg::sts_type sts;

   logic [mzn_pkg::SAMPLE_W-1:0] value, mean, deviation;
   logic [mzn_pkg::CNT_W-1:0]    nonzero_count;

   mzn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .sts        (sts),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   mzn_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_op        (req_tuser),
      .req_sample    (req_tdata[23:0]),
      .req_index     (req_tdata[35:24]),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_value     (value),
      .rsp_mean      (mean),
      .rsp_deviation (deviation),
      .rsp_count     (nonzero_count),
      .rsp_status    (rsp_tuser)
   );

   assign rsp_tdata = {3'b000, nonzero_count, deviation, mean, value};

   `MZN_ASSERT_NOW(a_accept_out_free, req_tvalid && req_tready, !rsp_tvalid || rsp_tready)
   `MZN_ASSERT_NEXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready)
   `MZN_ASSERT_NOW(a_empty_stats, rsp_tvalid && rsp_tuser == mzn_pkg::ST_EMPTY,
      rsp_tdata[84:72] == 13'd0 && rsp_tdata[47:24] == 24'd0)

endmodule

@@ tb/tb_masked_zscore_normalizer.sv @@
module tb_masked_zscore_normalizer;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [23:0] value;
      logic [23:0] mean;
      logic [23:0] dev;
      logic [12:0] cnt;
      logic [1:0]  status;
   } zs_word_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [23:0] sample;
      logic [11:0] idx;
      logic        known;
      zs_word_type want;
   } dir_row_type;

   localparam int DIR_ROWS = 19;
   localparam logic [63:0] SQ_SUM_MAX = 64'h3FFF_FFFF_FFFF_FFFF;
   localparam zs_word_type ZERO_OK = '{24'd0, 24'd0, 24'd0, 13'd0, mzn_pkg::ST_OK};

   dir_row_type dir_rows [DIR_ROWS] = '{
      '{mzn_pkg::OP_READ,    24'h000000, 12'd0,    1'b1,
        '{24'd0, 24'd0, 24'd0, 13'd0, mzn_pkg::ST_BAD}},
      '{mzn_pkg::OP_COMPUTE, 24'h000000, 12'd0,    1'b1,
        '{24'd0, 24'd0, 24'd0, 13'd0, mzn_pkg::ST_EMPTY}},
      '{mzn_pkg::OP_LOAD,    24'h7FFFFF, 12'd0,    1'b1,
        '{24'd0, 24'd0, 24'd0, 13'd1, mzn_pkg::ST_OK}},
      '{mzn_pkg::OP_LOAD,    24'h800000, 12'd0,    1'b0, ZERO_OK},
      '{mzn_pkg::OP_LOAD,    24'h000000, 12'd0,    1'b0, ZERO_OK},
      '{mzn_pkg::OP_LOAD,    24'h000123, 12'd0,    1'b0, ZERO_OK},
      '{mzn_pkg::OP_COMPUTE, 24'hFFFFFF, 12'hFFF,  1'b0, ZERO_OK},
      '{mzn_pkg::OP_READ,    24'h000000, 12'd0,    1'b0, ZERO_OK},
      '{mzn_pkg::OP_READ,    24'h000000, 12'd1,    1'b0, ZERO_OK},
      '{mzn_pkg::OP_READ,    24'h000000, 12'd2,    1'b0, ZERO_OK},
      '{mzn_pkg::OP_READ,    24'h000000, 12'd4,    1'b0, ZERO_OK},
      '{mzn_pkg::OP_READ,    24'hFFFFFF, 12'hFFF,  1'b0, ZERO_OK},
      '{mzn_pkg::OP_CLEAR,   24'hFFFFFF, 12'hFFF,  1'b1, ZERO_OK},
      // mean rounds to 2, deviation floors to zero
      '{mzn_pkg::OP_LOAD,    24'h000001, 12'd0,    1'b0, ZERO_OK},
      '{mzn_pkg::OP_LOAD,    24'h000002, 12'd0,    1'b0, ZERO_OK},
      '{mzn_pkg::OP_COMPUTE, 24'h000000, 12'd0,    1'b0, ZERO_OK},
      '{mzn_pkg::OP_READ,    24'h000000, 12'd0,    1'b0, ZERO_OK},
      '{mzn_pkg::OP_READ,    24'h000000, 12'd1,    1'b0, ZERO_OK},
      // a load drops the computed flag
      '{mzn_pkg::OP_LOAD,    24'h000005, 12'd0,    1'b0, ZERO_OK}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;  // sample[23:0], index[35:24], zero pad
   logic [1:0]  req_tuser = '0;  // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;       // value, mean, deviation, nonzero_count, zero pad
   logic [1:0]  rsp_tuser;       // status[1:0]

   logic        cur_known = 1'b0;
   zs_word_type cur_want = '0;
   logic        req_fire = 1'b0;

   // golden copy of the block state
   logic [23:0] gold_store [mzn_pkg::STORE_DEPTH];
   int unsigned gold_loaded, gold_tally;
   longint      gold_sum, gold_mean;
   longint unsigned gold_dev;
   bit          gold_ready;

   zs_word_type pending_q [$];
   int          fail_count = 0;
   int          item_count = 0;
   int unsigned host_loaded = 0;
   bit          calm = 1'b0;
   bit          long_hold_req = 1'b0;
   int          stall_left = 0;

   masked_zscore_normalizer i_dut (.*);

   always #10 clock = ~clock;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic void compute_zscore_stats();
      longint unsigned mag, q, acc, sq, root;
      longint d;
      bit neg;
      if (gold_tally == 0) begin
         gold_mean = 0;
         gold_dev = 0;
         gold_ready = 0;
         return;
      end
      neg = gold_sum < 0;
      mag = neg ? -gold_sum : gold_sum;
      q = (mag + gold_tally / 2) / gold_tally;
      gold_mean = neg ? -longint'(q) : longint'(q);
      acc = 0;
      for (int i = 0; i < gold_loaded; i++) begin
         d = longint'(signed'(gold_store[i])) - gold_mean;
         if (d < 0) d = -d;
         sq = d * d;
         if (sq > SQ_SUM_MAX - acc) acc = SQ_SUM_MAX;
         else acc += sq;
      end
      root = int_sqrt(acc / gold_tally);
      gold_dev = root > 64'hFFFFFF ? 64'hFFFFFF : root;
      gold_ready = 1;
   endfunction

   function automatic longint zscore_of(longint s);
      longint d, r;
      d = s - gold_mean;
      if (s == 0 || d == 0) return 0;
      if (gold_dev == 0) return d < 0 ? -8388608 : 8388607;
      r = (d * 65536) / longint'(gold_dev);
      if (r > 8388607) return 8388607;
      if (r < -8388608) return -8388608;
      return r;
   endfunction

   function automatic zs_word_type apply_command(logic [1:0] op, logic [23:0] s,
                                                 logic [11:0] idx);
      zs_word_type w;
      longint v;
      v = 0;
      w.status = mzn_pkg::ST_OK;
      case (op)
         mzn_pkg::OP_CLEAR: begin
            gold_loaded = 0; gold_sum = 0; gold_tally = 0;
            gold_mean = 0; gold_dev = 0; gold_ready = 0;
         end
         mzn_pkg::OP_LOAD: begin
            gold_ready = 0;
            if (gold_loaded >= mzn_pkg::STORE_DEPTH) begin
               w.status = mzn_pkg::ST_FULL;
            end else begin
               gold_store[gold_loaded] = s;
               gold_loaded++;
               if (s != 0) begin
                  gold_sum += longint'(signed'(s));
                  gold_tally++;
               end
            end
         end
         mzn_pkg::OP_COMPUTE: begin
            compute_zscore_stats();
            w.status = gold_ready ? mzn_pkg::ST_OK : mzn_pkg::ST_EMPTY;
         end
         default: begin
            if (!gold_ready || idx >= gold_loaded) w.status = mzn_pkg::ST_BAD;
            else v = zscore_of(longint'(signed'(gold_store[idx])));
         end
      endcase
      w.value = v[23:0];
      w.mean = gold_mean[23:0];
      w.dev = gold_dev[23:0];
      w.cnt = gold_tally[12:0];
      return w;
   endfunction

   // accepted command words feed the golden copy
   always @(posedge clock) begin
      zs_word_type w;
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         w = apply_command(req_tuser, req_tdata[23:0], req_tdata[35:24]);
         pending_q.push_back(cur_known ? cur_want : w);
      end
   end

   always @(posedge clock) begin
      zs_word_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_q.size() == 0) begin
            $error("unexpected result word");
            fail_count++;
         end else begin
            e = pending_q.pop_front();
            if (rsp_tdata[23:0] !== e.value) begin
               $error("value: expected %h, got %h", e.value, rsp_tdata[23:0]);
               fail_count++;
            end
            if (rsp_tdata[47:24] !== e.mean) begin
               $error("mean: expected %h, got %h", e.mean, rsp_tdata[47:24]);
               fail_count++;
            end
            if (rsp_tdata[71:48] !== e.dev) begin
               $error("deviation: expected %h, got %h", e.dev, rsp_tdata[71:48]);
               fail_count++;
            end
            if (rsp_tdata[84:72] !== e.cnt) begin
               $error("nonzero_count: expected %0d, got %0d", e.cnt, rsp_tdata[84:72]);
               fail_count++;
            end
            if (rsp_tuser !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   // result side backpressure
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 0;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_word(logic [1:0] op, logic [23:0] s, logic [11:0] idx,
                            logic known = 1'b0, zs_word_type want = '0);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {4'd0, idx, s};
      cur_known <= known;
      cur_want <= want;
      do @(negedge clock); while (!req_fire);
      item_count++;
      if (op == mzn_pkg::OP_CLEAR) host_loaded = 0;
      else if (op == mzn_pkg::OP_LOAD && host_loaded < mzn_pkg::STORE_DEPTH) host_loaded++;
   endtask

   function automatic logic [23:0] pick_sample();
      case ($urandom_range(0, 9))
         0, 1: return 24'd0;
         2: return 24'h7FFFFF;
         3: return 24'h800000;
         4, 5, 6: return 24'($urandom_range(0, 2000)) - 24'd1000;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [11:0] pick_index();
      if (host_loaded > 0 && $urandom_range(0, 7) != 0)
         return 12'($urandom_range(0, host_loaded - 1));
      return 12'($urandom);
   endfunction

   task automatic random_block(int upto);
      while (item_count < upto) begin
         if ($urandom_range(0, 11) == 0) begin
            send_word(2'($urandom), 24'($urandom), 12'($urandom));
         end else begin
            if ($urandom_range(0, 1) == 0)
               send_word(mzn_pkg::OP_CLEAR, 24'($urandom), 12'($urandom));
            repeat ($urandom_range(1, 30))
               send_word(mzn_pkg::OP_LOAD, pick_sample(), 12'($urandom));
            send_word(mzn_pkg::OP_COMPUTE, 24'($urandom), 12'($urandom));
            repeat ($urandom_range(3, 12))
               send_word(mzn_pkg::OP_READ, 24'($urandom), pick_index());
            if ($urandom_range(0, 3) == 0) begin
               send_word(mzn_pkg::OP_LOAD, pick_sample(), 12'($urandom));
               send_word(mzn_pkg::OP_READ, 24'($urandom), pick_index());
            end
         end
      end
   endtask

   initial begin
      gold_loaded = 0; gold_sum = 0; gold_tally = 0;
      gold_mean = 0; gold_dev = 0; gold_ready = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int i = 0; i < DIR_ROWS; i++)
         send_word(dir_rows[i].op, dir_rows[i].sample, dir_rows[i].idx,
                   dir_rows[i].known, dir_rows[i].want);
      send_word(mzn_pkg::OP_READ, 24'd0, 12'd0);
      random_block(700);
      // stall the result side while commands keep coming
      long_hold_req = 1;
      repeat (40) send_word(mzn_pkg::OP_LOAD, pick_sample(), 12'($urandom));
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(negedge clock);
      // statistics over everything loaded since the last clear
      send_word(mzn_pkg::OP_COMPUTE, 24'd0, 12'd0);
      send_word(mzn_pkg::OP_READ, 24'd0, 12'd0);
      send_word(mzn_pkg::OP_READ, 24'd0, 12'hFFF);
      send_word(mzn_pkg::OP_READ, 24'd0, pick_index());
      send_word(mzn_pkg::OP_CLEAR, 24'd0, 12'd0);
      random_block(item_count + 650);
      calm = 1;
      random_block(item_count + 200);
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

endmodule
